// ----- rtl/core/mbsp_pkg.sv -----
package mbsp_pkg;

    // Field widths of the byte stream and of the decoded events.
    localparam int unsigned ByteW  = 8;
    localparam int unsigned CodeW  = 5;
    localparam int unsigned ChanW  = 4;
    localparam int unsigned NeedW  = 2;
    localparam int unsigned NibW   = 4;

    // Status byte high nibbles.
    localparam logic [NibW-1:0] NibChanFirst = 4'h8;
    localparam logic [NibW-1:0] NibChanLast  = 4'hE;
    localparam logic [NibW-1:0] NibProgram   = 4'hC;
    localparam logic [NibW-1:0] NibPressure  = 4'hD;
    localparam logic [NibW-1:0] NibSystem    = 4'hF;

    // System message low nibbles.
    localparam logic [NibW-1:0] SysTimeCode  = 4'h1;
    localparam logic [NibW-1:0] SysSongPos   = 4'h2;
    localparam logic [NibW-1:0] SysSongSel   = 4'h3;
    localparam logic [NibW-1:0] SysTune      = 4'h6;
    localparam logic [NibW-1:0] SysClock     = 4'h8;
    localparam logic [NibW-1:0] SysStart     = 4'hA;
    localparam logic [NibW-1:0] SysContinue  = 4'hB;
    localparam logic [NibW-1:0] SysStop      = 4'hC;
    localparam logic [NibW-1:0] SysSensing   = 4'hE;
    localparam logic [NibW-1:0] SysReset     = 4'hF;

    // Event codes of system messages.
    localparam logic [CodeW-1:0] EvTimeCode  = 5'd7;
    localparam logic [CodeW-1:0] EvSongPos   = 5'd8;
    localparam logic [CodeW-1:0] EvSongSel   = 5'd9;
    localparam logic [CodeW-1:0] EvTune      = 5'd10;
    localparam logic [CodeW-1:0] EvClock     = 5'd12;
    localparam logic [CodeW-1:0] EvStart     = 5'd13;
    localparam logic [CodeW-1:0] EvContinue  = 5'd14;
    localparam logic [CodeW-1:0] EvStop      = 5'd15;
    localparam logic [CodeW-1:0] EvSensing   = 5'd16;
    localparam logic [CodeW-1:0] EvReset     = 5'd17;

    // Data byte counts a message needs.
    localparam logic [NeedW-1:0] NeedNone = 2'd0;
    localparam logic [NeedW-1:0] NeedOne  = 2'd1;
    localparam logic [NeedW-1:0] NeedTwo  = 2'd2;

    // Result of decoding one byte as a status byte.
    typedef struct packed {
        logic             known;
        logic [CodeW-1:0] code;
        logic [ChanW-1:0] chan;
        logic [NeedW-1:0] need;
    } t_status_info;

    // One decoded event.
    typedef struct packed {
        logic [CodeW-1:0] event_code;
        logic [ChanW-1:0] channel;
        logic [ByteW-1:0] data_lo;
        logic [ByteW-1:0] data_hi;
    } t_event;

endpackage

// ----- rtl/core/mbsp_byte_if.sv -----
interface mbsp_byte_if;
    logic                        valid;
    logic                        ready;
    logic [mbsp_pkg::ByteW-1:0]  midi_byte;

    modport source (output valid, output midi_byte, input ready);
    modport sink   (input valid, input midi_byte, output ready);
endinterface

// ----- rtl/core/mbsp_event_if.sv -----
interface mbsp_event_if;
    logic                        valid;
    logic                        ready;
    logic [mbsp_pkg::CodeW-1:0]  event_code;
    logic [mbsp_pkg::ChanW-1:0]  channel;
    logic [mbsp_pkg::ByteW-1:0]  data_lo;
    logic [mbsp_pkg::ByteW-1:0]  data_hi;

    modport source (output valid, output event_code, output channel,
                    output data_lo, output data_hi, input ready);
    modport sink   (input valid, input event_code, input channel,
                    input data_lo, input data_hi, output ready);
endinterface

// ----- rtl/core/mbsp_status_decode.sv -----
module mbsp_status_decode (
    input  logic [mbsp_pkg::ByteW-1:0] i_byte,
    output mbsp_pkg::t_status_info     o_info
);

    logic [mbsp_pkg::NibW-1:0] hi_nib;
    logic [mbsp_pkg::NibW-1:0] lo_nib;

    assign hi_nib = i_byte[mbsp_pkg::ByteW-1 -: mbsp_pkg::NibW];
    assign lo_nib = i_byte[mbsp_pkg::NibW-1:0];

    // Channel messages carry their channel; system messages decode the low nibble.
    always_comb begin
        o_info       = '0;
        o_info.known = 1'b0;
        if (hi_nib >= mbsp_pkg::NibChanFirst && hi_nib <= mbsp_pkg::NibChanLast) begin
            o_info.known = 1'b1;
            o_info.code  = {2'b00, hi_nib[2:0]};
            o_info.chan  = lo_nib;
            if (hi_nib == mbsp_pkg::NibProgram || hi_nib == mbsp_pkg::NibPressure) begin
                o_info.need = mbsp_pkg::NeedOne;
            end else begin
                o_info.need = mbsp_pkg::NeedTwo;
            end
        end else if (hi_nib == mbsp_pkg::NibSystem) begin
            o_info.known = 1'b1;
            unique case (lo_nib)
                mbsp_pkg::SysTimeCode: begin
                    o_info.code = mbsp_pkg::EvTimeCode;
                    o_info.need = mbsp_pkg::NeedOne;
                end
                mbsp_pkg::SysSongPos: begin
                    o_info.code = mbsp_pkg::EvSongPos;
                    o_info.need = mbsp_pkg::NeedTwo;
                end
                mbsp_pkg::SysSongSel: begin
                    o_info.code = mbsp_pkg::EvSongSel;
                    o_info.need = mbsp_pkg::NeedOne;
                end
                mbsp_pkg::SysTune:     o_info.code = mbsp_pkg::EvTune;
                mbsp_pkg::SysClock:    o_info.code = mbsp_pkg::EvClock;
                mbsp_pkg::SysStart:    o_info.code = mbsp_pkg::EvStart;
                mbsp_pkg::SysContinue: o_info.code = mbsp_pkg::EvContinue;
                mbsp_pkg::SysStop:     o_info.code = mbsp_pkg::EvStop;
                mbsp_pkg::SysSensing:  o_info.code = mbsp_pkg::EvSensing;
                mbsp_pkg::SysReset:    o_info.code = mbsp_pkg::EvReset;
                default:               o_info.known = 1'b0;
            endcase
        end
    end

endmodule

// ----- rtl/core/mbsp_parse_core.sv -----
module mbsp_parse_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  logic [mbsp_pkg::ByteW-1:0] i_byte,
    input  mbsp_pkg::t_status_info     i_info,
    output logic                       o_emit,
    output mbsp_pkg::t_event           o_event
);

    logic [mbsp_pkg::NeedW-1:0] r_need;
    logic [mbsp_pkg::NeedW-1:0] n_need;
    logic                       r_taken;
    logic                       n_taken;
    logic [mbsp_pkg::CodeW-1:0] r_code;
    logic [mbsp_pkg::CodeW-1:0] n_code;
    logic [mbsp_pkg::ChanW-1:0] r_chan;
    logic [mbsp_pkg::ChanW-1:0] n_chan;
    logic [mbsp_pkg::ByteW-1:0] r_first;
    logic [mbsp_pkg::ByteW-1:0] n_first;

    // Message assembly: status byte, then zero, one or two data bytes of any value.
    always_comb begin
        n_need  = r_need;
        n_taken = r_taken;
        n_code  = r_code;
        n_chan  = r_chan;
        n_first = r_first;
        o_emit  = 1'b0;
        o_event = '0;
        if (r_need == mbsp_pkg::NeedNone) begin
            if (i_info.known) begin
                if (i_info.need == mbsp_pkg::NeedNone) begin
                    o_emit             = 1'b1;
                    o_event.event_code = i_info.code;
                end else begin
                    n_need  = i_info.need;
                    n_taken = 1'b0;
                    n_code  = i_info.code;
                    n_chan  = i_info.chan;
                end
            end
        end else if (r_need[1] && !r_taken) begin
            n_first = i_byte;
            n_taken = 1'b1;
        end else begin
            o_emit             = 1'b1;
            o_event.event_code = r_code;
            o_event.channel    = r_chan;
            if (r_need == mbsp_pkg::NeedOne) begin
                o_event.data_lo = i_byte;
            end else begin
                o_event.data_lo = r_first;
                o_event.data_hi = i_byte;
            end
            n_need  = mbsp_pkg::NeedNone;
            n_taken = 1'b0;
        end
    end

    // Parser state advances only when a byte is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need  <= mbsp_pkg::NeedNone;
            r_taken <= 1'b0;
        end else if (i_go) begin
            r_need  <= n_need;
            r_taken <= n_taken;
        end
    end

    // Pending message fields, only read once written.
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_code  <= n_code;
            r_chan  <= n_chan;
            r_first <= n_first;
        end
    end

endmodule

// ----- rtl/core/midi_byte_stream_parser.sv -----
// Each byte is held in the input register, and the event that it completes is held in the output register.
// Throughput: one byte per cycle while the event sink keeps ready high; the single
// input register and the single output register set this figure.
// Reset (synchronous, active low) empties both registers and returns the parser
// to waiting for a status byte.
module midi_byte_stream_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mbsp_byte_if.sink     i_byte,
    mbsp_event_if.source  o_event
);

    logic                       r_in_valid;
    logic [mbsp_pkg::ByteW-1:0] r_in_byte;
    logic                       r_out_valid;
    mbsp_pkg::t_event           r_out_event;
    logic                       out_free;
    logic                       go;
    logic                       emit;
    mbsp_pkg::t_status_info     info;
    mbsp_pkg::t_event           event_nxt;

    // The held byte is processed whenever the output register can take a result.
    assign out_free     = !r_out_valid || o_event.ready;
    assign go           = r_in_valid && out_free;
    assign i_byte.ready = !r_in_valid || out_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.midi_byte;
        end
    end

    mbsp_status_decode u_decode (
        .i_byte (r_in_byte),
        .o_info (info)
    );

    mbsp_parse_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_byte  (r_in_byte),
        .i_info  (info),
        .o_emit  (emit),
        .o_event (event_nxt)
    );

    // Output register: a new result replaces one taken in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go) begin
            r_out_valid <= emit;
        end else if (o_event.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && emit) begin
            r_out_event <= event_nxt;
        end
    end

    assign o_event.valid      = r_out_valid;
    assign o_event.event_code = r_out_event.event_code;
    assign o_event.channel    = r_out_event.channel;
    assign o_event.data_lo    = r_out_event.data_lo;
    assign o_event.data_hi    = r_out_event.data_hi;

endmodule
